// File: hw/rtl/cts_pkg.sv
// Shared constants and types of the column-to-span converter.
`default_nettype none

package cts_pkg;

    localparam int ROWS_DEF    = 64;
    localparam int ROW_W       = 6;
    localparam int COL_W       = 10;
    localparam int SCOL_W      = 9;
    localparam int RV_W        = 7;
    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 24;

    // Row bound of an empty range; compares above every real row bound
    localparam logic [RV_W-1:0] ROW_EMPTY = 7'h7F;

    // One result request from the sequencer to the output stage
    typedef struct packed {
        logic              valid;
        logic              span;
        logic              last;
        logic [ROW_W-1:0]  row;
        logic [SCOL_W-1:0] last_col;
    } issue_t;

    // Output stage status seen by the sequencer
    typedef struct packed {
        logic slot_ok;
    } out_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/cts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module cts_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/cts_seq.sv
// Sequencer: walks the rows that close and open for one column.
`default_nettype none

module cts_seq #(
    parameter int ROWS = cts_pkg::ROWS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [cts_pkg::COL_W-1:0]    in_column,
    input  wire logic [cts_pkg::ROW_W-1:0]    in_top,
    input  wire logic [cts_pkg::ROW_W-1:0]    in_bottom,
    input  wire logic                         in_empty,
    input  wire logic                         in_first,
    input  wire cts_pkg::out_stat_t           stat,
    output cts_pkg::issue_t                   iss,
    output logic                              mem_wr_en,
    output logic [$clog2(ROWS)-1:0]           mem_wr_addr,
    output logic [cts_pkg::SCOL_W-1:0]        mem_wr_data,
    output logic                              mem_rd_en,
    output logic [$clog2(ROWS)-1:0]           mem_rd_addr
);

    import cts_pkg::*;

    localparam int AW = $clog2(ROWS);

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_CLOSE_TOP = 5'b00010,
        ST_CLOSE_BOT = 5'b00100,
        ST_OPEN_TOP  = 5'b01000,
        ST_OPEN_BOT  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [RV_W-1:0]   t1_reg, t1_next;
    logic [RV_W-1:0]   b1_reg, b1_next;
    logic [RV_W-1:0]   t2_reg, t2_next;
    logic [RV_W-1:0]   b2_reg, b2_next;
    logic [SCOL_W-1:0] x_reg, x_next;
    logic [SCOL_W-1:0] last_col_reg, last_col_next;
    logic              any_reg, any_next;
    logic [ROW_W-1:0]  prev_top_reg, prev_top_next;
    logic [ROW_W-1:0]  prev_bot_reg, prev_bot_next;
    logic              prev_empty_reg, prev_empty_next;

    logic [RV_W-1:0]   t1_inc;
    logic [RV_W-1:0]   b1_dec;

    // Rows past the memory depth land on its last entry
    function automatic logic [AW-1:0] row_addr(input logic [RV_W-1:0] r);
        row_addr = (r >= RV_W'(ROWS)) ? AW'(ROWS - 1) : r[AW-1:0];
    endfunction

    assign t1_inc      = t1_reg + RV_W'(1);
    assign b1_dec      = b1_reg - RV_W'(1);
    assign mem_wr_data = x_reg;

    always_comb
    begin
        state_next      = state_reg;
        t1_next         = t1_reg;
        b1_next         = b1_reg;
        t2_next         = t2_reg;
        b2_next         = b2_reg;
        x_next          = x_reg;
        last_col_next   = last_col_reg;
        any_next        = any_reg;
        prev_top_next   = prev_top_reg;
        prev_bot_next   = prev_bot_reg;
        prev_empty_next = prev_empty_reg;
        in_ready        = 1'b0;
        iss             = '0;
        iss.last_col    = last_col_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = row_addr(t2_reg);
        mem_rd_en       = 1'b0;
        mem_rd_addr     = row_addr(t1_reg);

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    t1_next         = (prev_empty_reg || in_first) ? ROW_EMPTY
                                                                   : {1'b0, prev_top_reg};
                    b1_next         = {1'b0, prev_bot_reg};
                    t2_next         = in_empty ? ROW_EMPTY : {1'b0, in_top};
                    b2_next         = {1'b0, in_bottom};
                    x_next          = in_column[SCOL_W-1:0];
                    last_col_next   = in_column[SCOL_W-1:0] - SCOL_W'(1);
                    any_next        = 1'b0;
                    prev_top_next   = in_top;
                    prev_bot_next   = in_bottom;
                    prev_empty_next = in_empty;
                    state_next      = ST_CLOSE_TOP;
                end
            end

            ST_CLOSE_TOP:
            begin
                if (t1_reg < t2_reg && t1_reg <= b1_reg)
                begin
                    if (stat.slot_ok)
                    begin
                        iss.valid = 1'b1;
                        iss.span  = 1'b1;
                        iss.row   = t1_reg[ROW_W-1:0];
                        iss.last  = !((t1_inc < t2_reg && t1_inc <= b1_reg) ||
                                      (b1_reg > b2_reg && b1_reg >= t1_inc));
                        mem_rd_en = 1'b1;
                        t1_next   = t1_inc;
                        any_next  = 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_CLOSE_BOT;
                end
            end

            ST_CLOSE_BOT:
            begin
                mem_rd_addr = row_addr(b1_reg);
                if (b1_reg > b2_reg && b1_reg >= t1_reg)
                begin
                    if (stat.slot_ok)
                    begin
                        iss.valid = 1'b1;
                        iss.span  = 1'b1;
                        iss.row   = b1_reg[ROW_W-1:0];
                        iss.last  = !(b1_dec > b2_reg && b1_dec >= t1_reg);
                        mem_rd_en = 1'b1;
                        b1_next   = b1_dec;
                        any_next  = 1'b1;
                    end
                end
                else if (any_reg)
                begin
                    state_next = ST_OPEN_TOP;
                end
                else if (stat.slot_ok)
                begin
                    // No span closed: send the empty marker transaction
                    iss.valid    = 1'b1;
                    iss.last     = 1'b1;
                    iss.last_col = '0;
                    state_next   = ST_OPEN_TOP;
                end
            end

            ST_OPEN_TOP:
            begin
                if (t2_reg < t1_reg && t2_reg <= b2_reg)
                begin
                    mem_wr_en = 1'b1;
                    t2_next   = t2_reg + RV_W'(1);
                end
                else
                begin
                    state_next = ST_OPEN_BOT;
                end
            end

            ST_OPEN_BOT:
            begin
                mem_wr_addr = row_addr(b2_reg);
                if (b2_reg > b1_reg && b2_reg >= t2_reg)
                begin
                    mem_wr_en = 1'b1;
                    b2_next   = b2_reg - RV_W'(1);
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            any_reg        <= 1'b0;
            prev_top_reg   <= '0;
            prev_bot_reg   <= '0;
            prev_empty_reg <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            any_reg        <= any_next;
            prev_top_reg   <= prev_top_next;
            prev_bot_reg   <= prev_bot_next;
            prev_empty_reg <= prev_empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg       <= t1_next;
        b1_reg       <= b1_next;
        t2_reg       <= t2_next;
        b2_reg       <= b2_next;
        x_reg        <= x_next;
        last_col_reg <= last_col_next;
    end

endmodule

`default_nettype wire

// File: hw/rtl/cts_out.sv
// Output stage: pairs read data with its request and queues results.
`default_nettype none

module cts_out (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire cts_pkg::issue_t            iss,
    input  wire logic [cts_pkg::SCOL_W-1:0] rd_data,
    output cts_pkg::out_stat_t              stat,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [cts_pkg::ROW_W-1:0]       m_row,
    output logic [cts_pkg::SCOL_W-1:0]      m_first_col,
    output logic [cts_pkg::SCOL_W-1:0]      m_last_col,
    output logic                            m_span,
    output logic                            m_last
);

    import cts_pkg::*;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [SCOL_W-1:0] first_col;
        logic [SCOL_W-1:0] last_col;
        logic              span;
        logic              last;
    } result_t;

    issue_t      pend_reg, pend_next;
    result_t     ent_reg [2];
    result_t     ent_new;
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    logic        pop;
    logic [2:0]  occ;

    assign push = pend_reg.valid;
    assign pop  = m_valid && m_ready;

    // Requests in flight plus queued results stay within the two entries
    assign occ          = 3'(count_reg) + 3'(pend_reg.valid) - 3'(pop);
    assign stat.slot_ok = occ < 3'd2;

    assign ent_new.row       = pend_reg.row;
    assign ent_new.first_col = pend_reg.span ? rd_data : '0;
    assign ent_new.last_col  = pend_reg.last_col;
    assign ent_new.span      = pend_reg.span;
    assign ent_new.last      = pend_reg.last;

    assign m_valid     = count_reg != 2'd0;
    assign m_row       = ent_reg[rd_ptr_reg].row;
    assign m_first_col = ent_reg[rd_ptr_reg].first_col;
    assign m_last_col  = ent_reg[rd_ptr_reg].last_col;
    assign m_span      = ent_reg[rd_ptr_reg].span;
    assign m_last      = ent_reg[rd_ptr_reg].last;

    always_comb
    begin
        pend_next   = iss;
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg   <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            pend_reg   <= pend_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= ent_new;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/column_to_span_converter.sv
// Top level of the column-to-span converter.
//
// Input stream s_axis: one transaction per screen column, left to right.
// Output stream m_axis: the horizontal spans that the column closes, rows
// leaving at the top ascending, then rows leaving at the bottom descending;
// tlast marks the final transaction of a column, tuser low means no span
// (one such transaction when a column closes nothing).
// Row start columns live in a synchronous RAM of ROWS entries; a closed row
// reads its start, a newly covered row writes the current column.
// Rows are walked at one RAM access per cycle while the result queue has
// room; the next column is accepted after the last RAM write.
// The first result reaches m_axis through the pending request register and
// the result queue; it is issued in the bottom-closing state when no top row closes.
// Reset clears the previous range to empty and the output queue; the RAM
// needs no clearing. When m_axis_tready is low the two-entry result queue
// fills and the sequencer holds until room frees up.
`default_nettype none

module column_to_span_converter #(
    parameter int ROWS = cts_pkg::ROWS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // column[9:0], top_row[15:10], bottom_row[21:16], zero pad[23:22]
    input  wire logic [cts_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // column_empty[0], first_column[1]
    input  wire logic [cts_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // span_row[5:0], span_first_col[14:6], span_last_col[23:15]
    output logic [cts_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // span_valid[0]
    output logic                                   m_axis_tuser,
    output logic                                   m_axis_tlast
);

    import cts_pkg::*;

    localparam int AW = $clog2(ROWS);

    issue_t             iss;
    out_stat_t          stat;
    logic               mem_wr_en;
    logic [AW-1:0]      mem_wr_addr;
    logic [SCOL_W-1:0]  mem_wr_data;
    logic               mem_rd_en;
    logic [AW-1:0]      mem_rd_addr;
    logic [SCOL_W-1:0]  mem_rd_data;
    logic [ROW_W-1:0]   span_row;
    logic [SCOL_W-1:0]  span_first_col;
    logic [SCOL_W-1:0]  span_last_col;

    cts_seq #(
        .ROWS (ROWS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_column   (s_axis_tdata[9:0]),
        .in_top      (s_axis_tdata[15:10]),
        .in_bottom   (s_axis_tdata[21:16]),
        .in_empty    (s_axis_tuser[0]),
        .in_first    (s_axis_tuser[1]),
        .stat        (stat),
        .iss         (iss),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr)
    );

    cts_ram #(
        .WIDTH (SCOL_W),
        .DEPTH (ROWS)
    ) u_start_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    cts_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .iss         (iss),
        .rd_data     (mem_rd_data),
        .stat        (stat),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_row       (span_row),
        .m_first_col (span_first_col),
        .m_last_col  (span_last_col),
        .m_span      (m_axis_tuser),
        .m_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {span_last_col, span_first_col, span_row};

    // A request goes out only when the result queue has room for it
    assert property (@(posedge clk) disable iff (!rst_n)
        iss.valid |-> stat.slot_ok)
        else $error("result request issued without queue room");

    // Start RAM is never read and written in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_wr_en && mem_rd_en))
        else $error("start RAM read and write overlap");

    // A new column is not taken right after one was accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    // A transaction without a span always closes its column
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("empty result not marked last");

endmodule

`default_nettype wire

// File: test/tb_column_to_span_converter.sv
// Self-checking testbench for the column-to-span converter stream block.
`timescale 1ns / 100ps

module tb_column_to_span_converter;

    localparam int          STALL_LIMIT = 4000;
    localparam int unsigned EMPTY_ROW   = 32'hFFFF_FFFF;
    localparam int          NROWS       = cts_pkg::ROWS_DEF;

    typedef struct {
        bit [cts_pkg::COL_W-1:0] column;
        bit [cts_pkg::ROW_W-1:0] top_row;
        bit [cts_pkg::ROW_W-1:0] bottom_row;
        bit                      column_empty;
        bit                      first_column;
    } column_item_t;

    typedef struct {
        bit [cts_pkg::ROW_W-1:0]  row;
        bit [cts_pkg::SCOL_W-1:0] first_col;
        bit [cts_pkg::SCOL_W-1:0] last_col;
        bit                       valid;
        bit                       last;
    } span_t;

    class span_scoreboard;
        bit [cts_pkg::SCOL_W-1:0] start_col [NROWS];
        bit                       start_set [NROWS];
        bit [cts_pkg::ROW_W-1:0]  prev_top;
        bit [cts_pkg::ROW_W-1:0]  prev_bottom;
        bit                       prev_empty;
        span_t                    pending_spans [$];
        int                       errors;
        int                       spans_seen;
        int                       blanks_seen;
        int                       columns_seen;

        function new();
            prev_top     = 0;
            prev_bottom  = 0;
            prev_empty   = 1;
            errors       = 0;
            spans_seen   = 0;
            blanks_seen  = 0;
            columns_seen = 0;
            foreach (start_set[i]) start_set[i] = 0;
        endfunction

        // Close and open rows for one column; without commit only report whether
        // a closed row would read a start column that was never stored.
        function bit walk_column(column_item_t c, bit commit);
            int unsigned              t1, b1, t2, b2;
            bit [cts_pkg::SCOL_W-1:0] last_col;
            bit                       unset_read;
            span_t                    closed [$];
            span_t                    s;
            unset_read = 0;
            last_col = c.column[cts_pkg::SCOL_W-1:0] - 1'b1;
            t1 = (prev_empty || c.first_column) ? EMPTY_ROW : prev_top;
            b1 = prev_bottom;
            t2 = c.column_empty ? EMPTY_ROW : c.top_row;
            b2 = c.bottom_row;
            while (t1 < t2 && t1 <= b1)
            begin
                if (!start_set[t1]) unset_read = 1;
                closed.push_back('{t1[5:0], start_col[t1], last_col, 1'b1, 1'b0});
                t1++;
            end
            while (b1 > b2 && b1 >= t1)
            begin
                if (!start_set[b1]) unset_read = 1;
                closed.push_back('{b1[5:0], start_col[b1], last_col, 1'b1, 1'b0});
                b1--;
            end
            if (!commit) return unset_read;
            while (t2 < t1 && t2 <= b2)
            begin
                start_col[t2] = c.column[cts_pkg::SCOL_W-1:0];
                start_set[t2] = 1;
                t2++;
            end
            while (b2 > b1 && b2 >= t2)
            begin
                start_col[b2] = c.column[cts_pkg::SCOL_W-1:0];
                start_set[b2] = 1;
                b2--;
            end
            prev_top    = c.top_row;
            prev_bottom = c.bottom_row;
            prev_empty  = c.column_empty;
            columns_seen++;
            if (closed.size() == 0) closed.push_back('{0, 0, 0, 1'b0, 1'b0});
            foreach (closed[i])
            begin
                s = closed[i];
                s.last = (i == closed.size() - 1);
                pending_spans.push_back(s);
            end
            return unset_read;
        endfunction

        function bit would_read_unset(column_item_t c);
            return walk_column(c, 0);
        endfunction

        function void note_column(column_item_t c);
            void'(walk_column(c, 1));
        endfunction

        function void compare(string field, int want, int got);
            if (want != got)
            begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_span(bit [5:0] row, bit [8:0] first_col, bit [8:0] last_col,
                                 bit valid, bit last);
            span_t want;
            if (pending_spans.size() == 0)
            begin
                $error("span result with no column pending: row %0d valid %0d", row, valid);
                errors++;
                return;
            end
            want = pending_spans.pop_front();
            if (valid) spans_seen++;
            else blanks_seen++;
            compare("span_row", want.row, row);
            compare("span_first_col", want.first_col, first_col);
            compare("span_last_col", want.last_col, last_col);
            compare("span_valid", want.valid, valid);
            compare("last_of_column", want.last, last);
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [cts_pkg::IN_TDATA_W-1:0]    s_axis_tdata = '0;
    logic [cts_pkg::IN_TUSER_W-1:0]    s_axis_tuser = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [cts_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
    logic                              m_axis_tuser;
    logic                              m_axis_tlast;

    span_scoreboard sb = new();
    int             items_in = 0;
    int             burst_left = 0;
    int             idle_cycles = 0;
    int             ready_cycle = 0;
    int             ready_mode = 0;
    int             hold_left = 0;
    bit             hold_done = 0;

    column_to_span_converter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic column_item_t make_column(int col, int top, int bot, bit e, bit f);
        column_item_t c;
        c.column       = 10'(col);
        c.top_row      = 6'(top);
        c.bottom_row   = 6'(bot);
        c.column_empty = e;
        c.first_column = f;
        return c;
    endfunction

    // Offer one column, hold it until accepted, then keep the burst or idle.
    task automatic send_column(column_item_t c);
        if (sb.would_read_unset(c)) c.first_column = 1'b1;
        s_axis_tdata  <= {2'b00, c.bottom_row, c.top_row, c.column};
        s_axis_tuser  <= {c.first_column, c.column_empty};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_column(c);
        items_in++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic run_directed();
        send_column(make_column(0, 0, 63, 0, 1));      // column zero, full height
        send_column(make_column(1, 0, 63, 0, 0));      // unchanged range closes nothing
        send_column(make_column(2, 5, 60, 0, 0));      // close at top and bottom
        send_column(make_column(3, 2, 62, 0, 0));      // reopen at both ends
        send_column(make_column(4, 9, 17, 1, 0));      // empty column closes all
        send_column(make_column(5, 10, 20, 0, 0));     // after empty nothing closes
        send_column(make_column(6, 20, 10, 0, 0));     // top below bottom
        send_column(make_column(7, 30, 40, 0, 0));
        send_column(make_column(8, 30, 40, 0, 1));     // new region over live rows
        send_column(make_column(9, 63, 63, 0, 0));
        send_column(make_column(10, 0, 0, 0, 0));
        send_column(make_column(511, 0, 63, 0, 0));
        send_column(make_column(512, 0, 63, 0, 0));    // wide column
        send_column(make_column(1023, 32, 32, 0, 0));
        send_column(make_column(0, 63, 63, 1, 1));     // empty and first together
        send_column(make_column(3, 0, 63, 1, 0));      // empty after empty
        send_column(make_column(4, 63, 0, 0, 1));
        send_column(make_column(5, 63, 63, 0, 0));
        send_column(make_column(6, 0, 63, 0, 0));
        send_column(make_column(7, 0, 63, 1, 0));
    endtask

    task automatic run_random(int target);
        int sent;
        int len;
        int t;
        int b;
        int col;
        sent = 0;
        while (sent < target)
        begin
            if ($urandom_range(0, 9) >= 8)
            begin
                send_column(make_column($urandom_range(0, 1023), $urandom_range(0, 63),
                                        $urandom_range(0, 63), $urandom_range(0, 1),
                                        $urandom_range(0, 1)));
                sent++;
            end
            else
            begin
                col = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                  : $urandom_range(0, 300);
                len = $urandom_range(1, 16);
                t = $urandom_range(0, 63);
                b = $urandom_range(t, 63);
                for (int i = 0; i < len; i++)
                begin
                    send_column(make_column(col, t, b, 0, i == 0));
                    col++;
                    sent++;
                    if ($urandom_range(0, 7) == 0)
                    begin
                        t = $urandom_range(0, 63);
                        b = $urandom_range(t, 63);
                    end
                    else
                    begin
                        t += int'($urandom_range(0, 6)) - 3;
                        b += int'($urandom_range(0, 6)) - 3;
                        if (t < 0) t = 0;
                        if (t > 63) t = 63;
                        if (b > 63) b = 63;
                        if (b < t) b = t;
                    end
                end
                // close the region with an empty column now and then
                if ($urandom_range(0, 2) == 0)
                begin
                    send_column(make_column(col, $urandom_range(0, 63), $urandom_range(0, 63),
                                            1, 0));
                    sent++;
                end
            end
        end
    endtask

    // Receiver: switch among four stall patterns, plus one long hold-off.
    always @(posedge clk)
    begin
        ready_cycle++;
        if (ready_cycle % 128 == 0) ready_mode = $urandom_range(0, 3);
        if (!hold_done && items_in >= 60)
        begin
            hold_done = 1;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case (ready_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= (ready_cycle % 7 < 4);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_span(m_axis_tdata[5:0], m_axis_tdata[14:6], m_axis_tdata[23:15],
                          m_axis_tuser, m_axis_tlast);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("column_to_span_converter: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random(130);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_spans.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        $display("ran %0d columns: %0d spans closed, %0d columns with no span",
                 sb.columns_seen, sb.spans_seen, sb.blanks_seen);
        $display("receiver held off for a long stretch: %0d", hold_done);
        if (sb.errors == 0)
            $display("column_to_span_converter: match");
        else
            $display("column_to_span_converter: mismatch");
        $finish;
    end

endmodule
